/* rtl/core/aqgc_pkg.sv */
`default_nettype none
package aqgc_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TABLE_LEN         = 24;
   localparam int RECIP_STEPS       = 25;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [29:0]        SQRT8_Q28   = 30'd759250125;

   // status flag bits
   localparam logic [1:0] FLAG_NONE      = 2'b00;
   localparam logic [1:0] FLAG_ZERO_DIST = 2'b01;
   localparam logic [1:0] FLAG_SAT       = 2'b10;

   typedef struct packed {
      logic [15:0] azimuth;
      logic [15:0] elevation;
      logic [15:0] source_distance;
   } req_type;

   typedef struct packed {
      logic signed [23:0] gain_front_left;
      logic signed [23:0] gain_front_right;
      logic signed [23:0] gain_back_left;
      logic signed [23:0] gain_back_right;
      logic [1:0]         status_flags;
   } rsp_type;

   function automatic logic signed [33:0] atan_phase(input int idx);
      logic signed [33:0] v;
      begin
         case (idx)
            0:  v = 34'sh20000000;
            1:  v = 34'sh12E4051D;
            2:  v = 34'sh09FB385B;
            3:  v = 34'sh051111D4;
            4:  v = 34'sh028B0D43;
            5:  v = 34'sh0145D7E1;
            6:  v = 34'sh00A2F61E;
            7:  v = 34'sh00517C55;
            8:  v = 34'sh0028BE53;
            9:  v = 34'sh00145F2F;
            10: v = 34'sh000A2F98;
            11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6;
            13: v = 34'sh000145F3;
            14: v = 34'sh0000A2F9;
            15: v = 34'sh0000517C;
            16: v = 34'sh000028BE;
            17: v = 34'sh0000145F;
            18: v = 34'sh00000A2F;
            19: v = 34'sh00000517;
            20: v = 34'sh0000028B;
            21: v = 34'sh00000145;
            22: v = 34'sh000000A2;
            23: v = 34'sh00000051;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/core/ambisonic_quad_gain_calc.sv */
// ambisonic_quad_gain_calc: four-speaker first-order ambisonic gains for one source
//
// req_ word: azimuth, elevation (binary angles, a full turn is 2^ANGLE_BITS) and
// source distance in unsigned Q8.8. rsp_ word: four signed Q12.12 gains and two
// status bits (zero distance, saturation). One response per request, in order.
//
// Throughput: one word per cycle while rsp_ready lets the pipeline advance. The
// angles are folded at the accept edge, 25 stages run the restoring reciprocal
// beside the CORDIC micro-rotations (stages past CORDIC_STAGES or past the 24-entry
// table just carry the vector), five stages form products, factors and gains, and
// the last register clamps and drives rsp_.
//
// All stages advance together; when rsp_ready is low and the output holds a
// word, the whole pipeline freezes, so nothing is lost or repeated, and
// req_ready drops. Empty slots are not squeezed out while stalled.
//
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module ambisonic_quad_gain_calc #(
   parameter int ANGLE_BITS    = aqgc_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = aqgc_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire aqgc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output aqgc_pkg::rsp_type      rsp_data
);

   localparam int NST   = (CORDIC_STAGES < aqgc_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : aqgc_pkg::TABLE_LEN;
   localparam int DEPTH = (NST > aqgc_pkg::RECIP_STEPS) ? NST : aqgc_pkg::RECIP_STEPS;
   localparam int NS    = DEPTH + 1;

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 0: fold angles
   logic signed [33:0] ax_ff [NS], ay_ff [NS], az_ff [NS];
   logic signed [33:0] ex_ff [NS], ey_ff [NS], ez_ff [NS];
   logic               af_ff [NS], ef_ff [NS];
   logic [24:0]        rem_ff [NS];
   logic [24:0]        quo_ff [NS];
   logic [15:0]        dist_ff [NS];
   logic               v_ff [NS];

   function automatic logic signed [33:0] fold_z(input logic [15:0] ang,
                                                 output logic flip);
      logic [31:0] ph;
      logic signed [33:0] z;
      begin
         ph = 32'(ang & 16'((32'd1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
         z  = 34'(signed'({2'b00, ph}));
         if (ph[31]) z = z - 34'sh100000000;
         flip = 1'b0;
         if (z >= 34'sh40000000) begin
            z = z - 34'sh80000000; flip = 1'b1;
         end else if (z < -34'sh40000000) begin
            z = z + 34'sh80000000; flip = 1'b1;
         end
         return z;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      logic fa, fe;
      logic signed [33:0] za, ze;
      if (advance) begin
         za = fold_z(req_data.azimuth, fa);
         ze = fold_z(req_data.elevation, fe);
         ax_ff[0] <= aqgc_pkg::CORDIC_GAIN; ay_ff[0] <= '0; az_ff[0] <= za; af_ff[0] <= fa;
         ex_ff[0] <= aqgc_pkg::CORDIC_GAIN; ey_ff[0] <= '0; ez_ff[0] <= ze; ef_ff[0] <= fe;
         dist_ff[0] <= req_data.source_distance;
         // rounded numerator 2^24 + d/2
         rem_ff[0]  <= 25'(25'h1000000 + 25'(req_data.source_distance >> 1));
         quo_ff[0]  <= '0;
         for (int i = 1; i < NS; i++) begin
            int k;
            logic [41:0] trial;
            logic [24:0] r;
            k = i - 1;
            if (k < NST) begin
               if (!az_ff[i-1][33]) begin
                  ax_ff[i] <= ax_ff[i-1] - (ay_ff[i-1] >>> k);
                  ay_ff[i] <= ay_ff[i-1] + (ax_ff[i-1] >>> k);
                  az_ff[i] <= az_ff[i-1] - aqgc_pkg::atan_phase(k);
               end else begin
                  ax_ff[i] <= ax_ff[i-1] + (ay_ff[i-1] >>> k);
                  ay_ff[i] <= ay_ff[i-1] - (ax_ff[i-1] >>> k);
                  az_ff[i] <= az_ff[i-1] + aqgc_pkg::atan_phase(k);
               end
               if (!ez_ff[i-1][33]) begin
                  ex_ff[i] <= ex_ff[i-1] - (ey_ff[i-1] >>> k);
                  ey_ff[i] <= ey_ff[i-1] + (ex_ff[i-1] >>> k);
                  ez_ff[i] <= ez_ff[i-1] - aqgc_pkg::atan_phase(k);
               end else begin
                  ex_ff[i] <= ex_ff[i-1] + (ey_ff[i-1] >>> k);
                  ey_ff[i] <= ey_ff[i-1] - (ex_ff[i-1] >>> k);
                  ez_ff[i] <= ez_ff[i-1] + aqgc_pkg::atan_phase(k);
               end
            end else begin
               ax_ff[i] <= ax_ff[i-1]; ay_ff[i] <= ay_ff[i-1]; az_ff[i] <= az_ff[i-1];
               ex_ff[i] <= ex_ff[i-1]; ey_ff[i] <= ey_ff[i-1]; ez_ff[i] <= ez_ff[i-1];
            end
            af_ff[i] <= af_ff[i-1]; ef_ff[i] <= ef_ff[i-1];
            dist_ff[i] <= dist_ff[i-1];
            // restoring division, one quotient bit per stage, msb first
            if (k < aqgc_pkg::RECIP_STEPS) begin
               trial = 42'(dist_ff[i-1]) << (aqgc_pkg::RECIP_STEPS - 1 - k);
               r = rem_ff[i-1];
               if (42'(r) >= trial) begin
                  rem_ff[i] <= 25'(42'(r) - trial);
                  quo_ff[i] <= quo_ff[i-1] | (25'd1 << (aqgc_pkg::RECIP_STEPS - 1 - k));
               end else begin
                  rem_ff[i] <= r;
                  quo_ff[i] <= quo_ff[i-1];
               end
            end else begin
               rem_ff[i] <= rem_ff[i-1];
               quo_ff[i] <= quo_ff[i-1];
            end
         end
      end
   end

   // tail stages
   logic signed [33:0] ca, sa, ce;
   always_comb begin
      ca = af_ff[NS-1] ? -ax_ff[NS-1] : ax_ff[NS-1];
      sa = af_ff[NS-1] ? -ay_ff[NS-1] : ay_ff[NS-1];
      ce = ef_ff[NS-1] ? -ex_ff[NS-1] : ex_ff[NS-1];
   end

   // t1: products
   logic signed [67:0] px_ff, py_ff;
   logic [24:0]        s1_ff;
   logic               z1_ff, v1_ff;
   // t2: factors
   logic signed [33:0] f_ff [4];
   logic [24:0]        s2_ff;
   logic               z2_ff, v2_ff;
   // t3: distance-scaled factors
   logic signed [60:0] sf_ff [4];
   logic               z3_ff, v3_ff;
   // t4: p, then t5: gain product
   logic signed [31:0] p_ff [4];
   logic               z4_ff, v4_ff;
   logic signed [63:0] gp_ff [4];
   logic               z5_ff, v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (advance) begin
         v1_ff <= v_ff[NS-1]; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff; rsp_valid <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [33:0] xc, yc;
      logic signed [33:0] g;
      logic sat;
      if (advance) begin
         px_ff <= ca * ce;
         py_ff <= sa * ce;
         s1_ff <= quo_ff[NS-1];
         z1_ff <= (dist_ff[NS-1] == 16'd0);

         xc = 34'((px_ff + 68'sd536870912) >>> 30);
         yc = 34'((py_ff + 68'sd536870912) >>> 30);
         f_ff[0] <= 34'sh40000000 + xc + yc;
         f_ff[1] <= 34'sh40000000 + xc - yc;
         f_ff[2] <= 34'sh40000000 - xc + yc;
         f_ff[3] <= 34'sh40000000 - xc - yc;
         s2_ff <= s1_ff; z2_ff <= z1_ff;

         for (int j = 0; j < 4; j++) begin
            sf_ff[j] <= 61'(signed'({1'b0, s2_ff[24:0]})) * 61'(f_ff[j]);
            p_ff[j]  <= 32'((sf_ff[j] + 61'sd536870912) >>> 30);
            gp_ff[j] <= 64'(p_ff[j]) * 64'(signed'({1'b0, aqgc_pkg::SQRT8_Q28}));
         end
         z3_ff <= z2_ff; z4_ff <= z3_ff; z5_ff <= z4_ff;

         sat = 1'b0;
         for (int j = 0; j < 4; j++) begin
            g = 34'((gp_ff[j] + 64'sh80000000) >>> 32);
            if (g > 34'sd8388607) begin
               g = 34'sd8388607; sat = 1'b1;
            end else if (g < -34'sd8388608) begin
               g = -34'sd8388608; sat = 1'b1;
            end
            if (z5_ff) g = '0;
            case (j)
               0: rsp_data.gain_front_left  <= 24'(g);
               1: rsp_data.gain_front_right <= 24'(g);
               2: rsp_data.gain_back_left   <= 24'(g);
               default: rsp_data.gain_back_right <= 24'(g);
            endcase
         end
         rsp_data.status_flags <= z5_ff ? aqgc_pkg::FLAG_ZERO_DIST
                                        : (sat ? aqgc_pkg::FLAG_SAT : aqgc_pkg::FLAG_NONE);
      end
   end

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS    = aqgc_pkg::ANGLE_BITS_DEF;
   localparam int CORDIC_STAGES = aqgc_pkg::CORDIC_STAGES_DEF;
   localparam int PIPE_DEPTH    = 31;
   localparam int N_RANDOM      = 1400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   aqgc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   aqgc_pkg::rsp_type rsp_data;

   ambisonic_quad_gain_calc #(
      .ANGLE_BITS(ANGLE_BITS),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("ambisonic_quad_gain_calc: mismatch");
      $finish;
   end

   aqgc_pkg::rsp_type gains_pending[$];
   int      n_errors = 0;
   bit      stim_done = 1'b0;

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_sh(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // rotation-mode cordic on a folded 32-bit phase
   function automatic void sin_cos(logic [15:0] ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit     flip;
      logic [31:0] ph;
      ph = 32'(ang & ((1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
      z = longint'(ph);
      x = longint'(aqgc_pkg::CORDIC_GAIN);
      y = 0;
      flip = 1'b0;
      if (z >= (longint'(1) << 31)) z -= (longint'(1) << 32);
      if (z >= (longint'(1) << 30)) begin
         z -= (longint'(1) << 31);
         flip = 1'b1;
      end else if (z < -(longint'(1) << 30)) begin
         z += (longint'(1) << 31);
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < aqgc_pkg::TABLE_LEN; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(aqgc_pkg::atan_phase(i));
         end else begin
            x += dx;
            y -= dy;
            z += longint'(aqgc_pkg::atan_phase(i));
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic aqgc_pkg::rsp_type quad_gains(aqgc_pkg::req_type r);
      aqgc_pkg::rsp_type o;
      longint  ca, sa, ce, se, xc, yc, s16, f, p, g;
      longint  gv[4];
      o = '0;
      if (r.source_distance == 0) begin
         o.status_flags = aqgc_pkg::FLAG_ZERO_DIST;
         return o;
      end
      sin_cos(r.azimuth, ca, sa);
      sin_cos(r.elevation, ce, se);
      xc = round_sh(ca * ce, 30);
      yc = round_sh(sa * ce, 30);
      s16 = ((longint'(1) << 24) + (r.source_distance >> 1)) / r.source_distance;
      for (int k = 0; k < 4; k++) begin
         f = (longint'(1) << 30) + ((k < 2) ? xc : -xc) + ((k % 2 == 0) ? yc : -yc);
         p = round_sh(s16 * f, 30);
         g = round_sh(p * longint'(aqgc_pkg::SQRT8_Q28), 32);
         if (g > 8388607) begin
            g = 8388607;
            o.status_flags |= aqgc_pkg::FLAG_SAT;
         end else if (g < -8388608) begin
            g = -8388608;
            o.status_flags |= aqgc_pkg::FLAG_SAT;
         end
         gv[k] = g;
      end
      o.gain_front_left  = gv[0][23:0];
      o.gain_front_right = gv[1][23:0];
      o.gain_back_left   = gv[2][23:0];
      o.gain_back_right  = gv[3][23:0];
      return o;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // directed words; zero-distance rows carry their typed-in result
   typedef struct {
      aqgc_pkg::req_type w;
      bit                fixed;
      aqgc_pkg::rsp_type res;
   } dir_row_type;

   dir_row_type dir_tab[$];

   // valid drops only when a gap follows, so back-to-back words keep it high
   task automatic send_word(aqgc_pkg::req_type w, bit fixed, aqgc_pkg::rsp_type res);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      gains_pending.push_back(fixed ? res : quad_gains(w));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      aqgc_pkg::req_type w;
      int      m;
      dir_tab.push_back('{'{16'h0000, 16'h0000, 16'h0000}, 1,
                          '{0, 0, 0, 0, aqgc_pkg::FLAG_ZERO_DIST}});
      dir_tab.push_back('{'{16'hFFFF, 16'hFFFF, 16'h0000}, 1,
                          '{0, 0, 0, 0, aqgc_pkg::FLAG_ZERO_DIST}});
      dir_tab.push_back('{'{16'h1234, 16'h8000, 16'h0000}, 1,
                          '{0, 0, 0, 0, aqgc_pkg::FLAG_ZERO_DIST}});
      dir_tab.push_back('{'{16'h0000, 16'h0000, 16'h0001}, 0, '0});
      dir_tab.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, '0});
      dir_tab.push_back('{'{16'h0000, 16'h0000, 16'h0100}, 0, '0});
      dir_tab.push_back('{'{16'h4000, 16'h0000, 16'h0100}, 0, '0});
      dir_tab.push_back('{'{16'h8000, 16'h0000, 16'h0100}, 0, '0});
      dir_tab.push_back('{'{16'hC000, 16'h0000, 16'h0100}, 0, '0});
      dir_tab.push_back('{'{16'h3FFF, 16'h4000, 16'h0080}, 0, '0});
      dir_tab.push_back('{'{16'h2000, 16'hC000, 16'h0200}, 0, '0});
      dir_tab.push_back('{'{16'h7FFF, 16'h8000, 16'h0002}, 0, '0});
      dir_tab.push_back('{'{16'hBFFF, 16'h2000, 16'h8000}, 0, '0});
      dir_tab.push_back('{'{16'hAAAA, 16'h5555, 16'h5555}, 0, '0});
      dir_tab.push_back('{'{16'h5555, 16'hAAAA, 16'hAAAA}, 0, '0});
      dir_tab.push_back('{'{16'h0001, 16'hFFFF, 16'h0003}, 0, '0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].res);
      for (int n = 0; n < N_RANDOM; n++) begin
         w.azimuth   = 16'($urandom);
         w.elevation = 16'($urandom);
         m = $urandom_range(0, 99);
         // often near sources (distance below 1.0), where the gains are large
         if (m < 3) w.source_distance = '0;
         else if (m < 40) w.source_distance = 16'($urandom_range(1, 255));
         else w.source_distance = 16'($urandom);
         send_word(w, 1'b0, '0);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // response side: random backpressure with occasional long stalls
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (rsp_ready) begin
            g = gap_len();
            if (g != 0) begin
               rsp_ready <= 1'b0;
               repeat (g - 1) @(posedge clock);
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      aqgc_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gains_pending.size() == 0) begin
            $error("unexpected word %h", rsp_data);
            n_errors++;
         end else begin
            e = gains_pending.pop_front();
            if (rsp_data.gain_front_left !== e.gain_front_left) begin
               $error("gain_front_left exp %0d got %0d", e.gain_front_left,
                      rsp_data.gain_front_left);
               n_errors++;
            end
            if (rsp_data.gain_front_right !== e.gain_front_right) begin
               $error("gain_front_right exp %0d got %0d", e.gain_front_right,
                      rsp_data.gain_front_right);
               n_errors++;
            end
            if (rsp_data.gain_back_left !== e.gain_back_left) begin
               $error("gain_back_left exp %0d got %0d", e.gain_back_left,
                      rsp_data.gain_back_left);
               n_errors++;
            end
            if (rsp_data.gain_back_right !== e.gain_back_right) begin
               $error("gain_back_right exp %0d got %0d", e.gain_back_right,
                      rsp_data.gain_back_right);
               n_errors++;
            end
            if (rsp_data.status_flags !== e.status_flags) begin
               $error("status_flags exp %0d got %0d", e.status_flags,
                      rsp_data.status_flags);
               n_errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (gains_pending.size() != 0) @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (n_errors == 0 && gains_pending.size() == 0) begin
         $display("ambisonic_quad_gain_calc: match");
      end else begin
         $display("ambisonic_quad_gain_calc: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/aqgc_pkg.sv
rtl/core/ambisonic_quad_gain_calc.sv
tb/tb.sv
